>>> rtl/core/qxmm_pkg.sv
// ----------------------------------------------------------------------------
// qxmm_pkg
// Shared widths, types, register indexes and mix signs for the X-quad mixer.
// ----------------------------------------------------------------------------
package qxmm_pkg;

   localparam int CMD_W      = 11;
   localparam int SUM_W      = 15;   // covers -16384..16383, enough for all mix math
   localparam int NUM_MOTORS = 4;
   localparam int CSR_IDX_W  = 3;

   typedef logic [CMD_W-1:0]        cmd_type;
   typedef logic signed [CMD_W-1:0] corr_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef sum_type                 sum_vec_type [NUM_MOTORS];

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_THROTTLE      = 3'd0,
      CSR_MIN_THROTTLE      = 3'd1,
      CSR_STOP_COMMAND      = 3'd2,
      CSR_STICK_CHECK_LEVEL = 3'd3,
      CSR_YAW_REVERSE       = 3'd4
   } csr_index_type;

   localparam int MOTOR_REAR_RIGHT  = 0;
   localparam int MOTOR_FRONT_RIGHT = 1;
   localparam int MOTOR_REAR_LEFT   = 2;
   localparam int MOTOR_FRONT_LEFT  = 3;

   // Negate flags per motor: bit 2 roll, bit 1 pitch, bit 0 yaw.
   localparam logic [2:0] MIX_NEG [NUM_MOTORS] = '{3'b101, 3'b110, 3'b000, 3'b011};

   localparam cmd_type MAX_THROTTLE_RST = 11'd1850;
   localparam cmd_type MIN_THROTTLE_RST = 11'd1150;
   localparam cmd_type STOP_COMMAND_RST = 11'd1000;
   localparam cmd_type STICK_CHECK_RST  = 11'd1100;

   typedef struct packed {
      cmd_type max_thr;
      cmd_type min_thr;
      cmd_type stop_cmd;
      logic    force_min;
      logic    disarm;
   } limit_ctl_type;

   function automatic sum_type apply_sign(input sum_type v, input logic neg);
      return neg ? sum_type'(-v) : v;
   endfunction

   function automatic sum_type widen_cmd(input cmd_type v);
      return sum_type'({{(SUM_W-CMD_W){1'b0}}, v});
   endfunction

   function automatic sum_type widen_corr(input corr_type v);
      return sum_type'({{(SUM_W-CMD_W){v[CMD_W-1]}}, v});
   endfunction

endpackage

>>> rtl/core/qxmm_mix.sv
// ----------------------------------------------------------------------------
// qxmm_mix
// Forms the four signed motor sums and their maximum.
// ----------------------------------------------------------------------------
module qxmm_mix (
   input  qxmm_pkg::cmd_type     throttle_cmd,
   input  qxmm_pkg::corr_type    roll_corr,
   input  qxmm_pkg::corr_type    pitch_corr,
   input  qxmm_pkg::corr_type    yaw_corr,
   input  logic                  yaw_reverse,
   output qxmm_pkg::sum_vec_type mix_sum,
   output qxmm_pkg::sum_type     peak
);
   import qxmm_pkg::*;

   sum_type thr_w;
   sum_type roll_w;
   sum_type pitch_w;
   sum_type yaw_w;
   sum_type peak_a;
   sum_type peak_b;

   always_comb begin
      thr_w   = widen_cmd(throttle_cmd);
      roll_w  = widen_corr(roll_corr);
      pitch_w = widen_corr(pitch_corr);
      yaw_w   = apply_sign(widen_corr(yaw_corr), yaw_reverse);
   end

   for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_sum
      assign mix_sum[m] = thr_w
                        + apply_sign(roll_w,  MIX_NEG[m][2])
                        + apply_sign(pitch_w, MIX_NEG[m][1])
                        + apply_sign(yaw_w,   MIX_NEG[m][0]);
   end

   // two-level max tree
   always_comb begin
      peak_a = (mix_sum[1] > mix_sum[0]) ? mix_sum[1] : mix_sum[0];
      peak_b = (mix_sum[3] > mix_sum[2]) ? mix_sum[3] : mix_sum[2];
      peak   = (peak_b > peak_a) ? peak_b : peak_a;
   end

endmodule

>>> rtl/core/qxmm_limit.sv
// ----------------------------------------------------------------------------
// qxmm_limit
// Normalizes one motor sum against the peak, clamps it and applies overrides.
// ----------------------------------------------------------------------------
module qxmm_limit (
   input  qxmm_pkg::sum_type       mix_sum,
   input  qxmm_pkg::sum_type       peak,
   input  qxmm_pkg::limit_ctl_type ctl,
   output qxmm_pkg::cmd_type       motor
);
   import qxmm_pkg::*;

   sum_type hi;
   sum_type lo;
   sum_type norm;
   sum_type clamped;

   always_comb begin
      hi   = widen_cmd(ctl.max_thr);
      lo   = widen_cmd(ctl.min_thr);
      // shift all motors down by the excess over the ceiling
      norm = (peak > hi) ? sum_type'(mix_sum - (peak - hi)) : mix_sum;
      // if the limits cross, sums below lo get lo and all others get hi
      if (norm < lo) begin
         clamped = lo;
      end else if (norm > hi) begin
         clamped = hi;
      end else begin
         clamped = norm;
      end
      if (ctl.disarm) begin
         motor = ctl.stop_cmd;
      end else if (ctl.force_min) begin
         motor = ctl.min_thr;
      end else begin
         motor = clamped[CMD_W-1:0];
      end
   end

endmodule

>>> rtl/core/quad_x_motor_mixer.sv
// Path: a req transfer is captured in the input register, then in the result
// register, which raises rsp_valid; a stall can hold it in the input register.
// Throughput: one control set per cycle unless the consumer stalls; the mix, max
// tree and clamps sit in one combinational pass between the two registers.
// Reset: synchronous, active high; clears both valid flags and loads the limit
// registers with their defaults (1850 / 1150 / 1000 / 1100, yaw not reversed).
// ----------------------------------------------------------------------------
// quad_x_motor_mixer
// X-quad motor mixer: sums throttle with roll, pitch and yaw corrections,
// normalizes against the ceiling, clamps and applies idle and disarm overrides.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer (
   input  logic                               clock,
   input  logic                               reset,
   // control set
   input  logic                               req_valid,
   output logic                               req_ready,
   input  qxmm_pkg::cmd_type                  req_throttle_cmd,
   input  qxmm_pkg::corr_type                 req_roll_corr,
   input  qxmm_pkg::corr_type                 req_pitch_corr,
   input  qxmm_pkg::corr_type                 req_yaw_corr,
   input  qxmm_pkg::cmd_type                  req_throttle_stick,
   input  logic                               req_alt_hold,
   input  logic                               req_armed,
   // motor commands
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output qxmm_pkg::cmd_type                  rsp_motor_rear_right,
   output qxmm_pkg::cmd_type                  rsp_motor_front_right,
   output qxmm_pkg::cmd_type                  rsp_motor_rear_left,
   output qxmm_pkg::cmd_type                  rsp_motor_front_left,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [qxmm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  qxmm_pkg::cmd_type                  csr_data
);
   import qxmm_pkg::*;

   // ------------------------------------------------------------------------
   // Configuration registers. Each write is stored on the clock edge; unknown indexes drop.
   // ------------------------------------------------------------------------
   cmd_type max_throttle_ff, max_throttle_in;
   cmd_type min_throttle_ff, min_throttle_in;
   cmd_type stop_command_ff, stop_command_in;
   cmd_type stick_check_ff,  stick_check_in;
   logic    yaw_reverse_ff,  yaw_reverse_in;
   logic    csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      max_throttle_in = max_throttle_ff;
      min_throttle_in = min_throttle_ff;
      stop_command_in = stop_command_ff;
      stick_check_in  = stick_check_ff;
      yaw_reverse_in  = yaw_reverse_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_THROTTLE:      max_throttle_in = csr_data;
            CSR_MIN_THROTTLE:      min_throttle_in = csr_data;
            CSR_STOP_COMMAND:      stop_command_in = csr_data;
            CSR_STICK_CHECK_LEVEL: stick_check_in  = csr_data;
            CSR_YAW_REVERSE:       yaw_reverse_in  = csr_data[0];
            default:               ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_throttle_ff <= MAX_THROTTLE_RST;
         min_throttle_ff <= MIN_THROTTLE_RST;
         stop_command_ff <= STOP_COMMAND_RST;
         stick_check_ff  <= STICK_CHECK_RST;
         yaw_reverse_ff  <= 1'b0;
      end else begin
         max_throttle_ff <= max_throttle_in;
         min_throttle_ff <= min_throttle_in;
         stop_command_ff <= stop_command_in;
         stick_check_ff  <= stick_check_in;
         yaw_reverse_ff  <= yaw_reverse_in;
      end
   end

   // ------------------------------------------------------------------------
   // Handshake. The result register advances when empty or being drained;
   // the input register advances when its content can move on. Unless the consumer
   // stalls, this is a full-rate two-stage pipe that still accepts while a result waits.
   // ------------------------------------------------------------------------
   logic in_valid_ff,  in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_load;
   logic in_load;

   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || rsp_load;
   assign in_load   = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = in_valid_ff;
      end
      if (req_ready) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ------------------------------------------------------------------------
   // Input register: capture the control set on each transfer.
   // ------------------------------------------------------------------------
   cmd_type  throttle_ff;
   corr_type roll_ff;
   corr_type pitch_ff;
   corr_type yaw_ff;
   cmd_type  stick_ff;
   logic     alt_hold_ff;
   logic     armed_ff;

   always_ff @(posedge clock) begin
      if (in_load) begin
         throttle_ff <= req_throttle_cmd;
         roll_ff     <= req_roll_corr;
         pitch_ff    <= req_pitch_corr;
         yaw_ff      <= req_yaw_corr;
         stick_ff    <= req_throttle_stick;
         alt_hold_ff <= req_alt_hold;
         armed_ff    <= req_armed;
      end
   end

   // ------------------------------------------------------------------------
   // Mix and limit: four sums and the peak, then per-motor normalize, clamp
   // and overrides (disarm wins over stick idle).
   // ------------------------------------------------------------------------
   sum_vec_type   mix_sum;
   sum_type       peak;
   limit_ctl_type limit_ctl;
   cmd_type       motor_cmd [NUM_MOTORS];

   qxmm_mix u_mix (
      .throttle_cmd (throttle_ff),
      .roll_corr    (roll_ff),
      .pitch_corr   (pitch_ff),
      .yaw_corr     (yaw_ff),
      .yaw_reverse  (yaw_reverse_ff),
      .mix_sum      (mix_sum),
      .peak         (peak)
   );

   always_comb begin
      limit_ctl.max_thr   = max_throttle_ff;
      limit_ctl.min_thr   = min_throttle_ff;
      limit_ctl.stop_cmd  = stop_command_ff;
      limit_ctl.force_min = (stick_ff < stick_check_ff) && !alt_hold_ff;
      limit_ctl.disarm    = !armed_ff;
   end

   for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_limit
      qxmm_limit u_limit (
         .mix_sum (mix_sum[m]),
         .peak    (peak),
         .ctl     (limit_ctl),
         .motor   (motor_cmd[m])
      );
   end

   // ------------------------------------------------------------------------
   // Result register: hold while the consumer stalls.
   // ------------------------------------------------------------------------
   cmd_type motor_rr_ff;
   cmd_type motor_fr_ff;
   cmd_type motor_rl_ff;
   cmd_type motor_fl_ff;

   always_ff @(posedge clock) begin
      if (rsp_load && in_valid_ff) begin
         motor_rr_ff <= motor_cmd[MOTOR_REAR_RIGHT];
         motor_fr_ff <= motor_cmd[MOTOR_FRONT_RIGHT];
         motor_rl_ff <= motor_cmd[MOTOR_REAR_LEFT];
         motor_fl_ff <= motor_cmd[MOTOR_FRONT_LEFT];
      end
   end

   assign rsp_motor_rear_right  = motor_rr_ff;
   assign rsp_motor_front_right = motor_fr_ff;
   assign rsp_motor_rear_left   = motor_rl_ff;
   assign rsp_motor_front_left  = motor_fl_ff;

`ifndef SYNTH
   // A captured item must not vanish while the result register is blocked.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_load) |=> in_valid_ff)
      else $error("input stage dropped an item");

   // Disarmed item yields the stop command on the rear-right and front-left motors.
   a_disarm_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && in_valid_ff && !armed_ff) |=>
         (rsp_motor_rear_right == $past(stop_command_ff)) &&
         (rsp_motor_front_left == $past(stop_command_ff)))
      else $error("disarmed result differs from stop command");

   // Armed result never exceeds the ceiling when the limits are ordered.
   a_ceiling: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && in_valid_ff && armed_ff && (max_throttle_ff >= min_throttle_ff)) |=>
         (rsp_motor_rear_right <= $past(max_throttle_ff)) &&
         (rsp_motor_front_right <= $past(max_throttle_ff)) &&
         (rsp_motor_rear_left <= $past(max_throttle_ff)) &&
         (rsp_motor_front_left <= $past(max_throttle_ff)))
      else $error("motor command above max throttle");
`endif

endmodule
